@@ hw/rtl/iswi_pkg.sv @@
`default_nettype none

package iswi_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned SRC_W = 6;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SHIFT = 5'b00010,
    ST_PLACE = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic ovf;
    logic shift;
    logic place;
    logic emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic less;
    logic j_one;
    logic last_held;
    logic emit_last;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/iswi_ram.sv @@
`default_nettype none

module iswi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/iswi_ctrl.sv @@
`default_nettype none

module iswi_ctrl
  import iswi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic last_key,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy
);

  state_t state, state_next;
  logic   accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (sts.full) begin
            cmd.ovf = 1'b1;
            if (last_key) begin
              state_next = ST_EMIT;
            end
          end else begin
            cmd.load = 1'b1;
            state_next = sts.empty ? ST_PLACE : ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        if (sts.less) begin
          cmd.shift = 1'b1;
          if (sts.j_one) begin
            state_next = ST_PLACE;
          end
        end else begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd.place  = 1'b1;
        state_next = sts.last_held ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/iswi_dp.sv @@
`default_nettype none

module iswi_dp
  import iswi_pkg::*;
#(
  parameter int unsigned SIZE = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cmd_t                    cmd,
  input  wire logic signed [KEY_W-1:0] key,
  input  wire logic                    last_key,
  output sts_t                         sts,
  output logic                         strobe,
  output logic signed [KEY_W-1:0]      sorted_key,
  output logic        [SRC_W-1:0]      source_index,
  output logic                         last_out,
  output logic                         overflowed
);

  localparam int unsigned AW = $clog2(SIZE);
  localparam int unsigned CW = $clog2(SIZE + 1);
  localparam int unsigned DW = KEY_W + AW;

  logic [CW-1:0]    count;
  logic [CW-1:0]    cnt_m1;
  logic             ovf;
  logic [AW-1:0]    j;
  logic [AW-1:0]    e;
  logic [KEY_W-1:0] keyr;
  logic             lastr;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [DW-1:0]    wdata;
  logic [AW-1:0]    raddr;
  logic [DW-1:0]    rdata;

  iswi_ram #(
    .WIDTH(DW),
    .DEPTH(SIZE)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign cnt_m1 = count - CW'(1);

  always_comb begin
    if (cmd.shift) begin
      raddr = j - AW'(2);
    end else if (cmd.emit) begin
      raddr = e;
    end else begin
      raddr = cnt_m1[AW-1:0];
    end
  end

  assign we    = cmd.shift | cmd.place;
  assign waddr = j;
  assign wdata = cmd.shift ? rdata : {count[AW-1:0], keyr};

  assign sts.full      = (count == CW'(SIZE));
  assign sts.empty     = (count == '0);
  assign sts.less      = $signed(keyr) < $signed(rdata[KEY_W-1:0]);
  assign sts.j_one     = (j == AW'(1));
  assign sts.last_held = lastr;
  assign sts.emit_last = (CW'(e) == cnt_m1);

  assign sorted_key   = rdata[KEY_W-1:0];
  assign source_index = SRC_W'(rdata[DW-1:KEY_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf      <= 1'b0;
      e        <= '0;
      lastr    <= 1'b0;
      strobe   <= 1'b0;
      last_out <= 1'b0;
    end else begin
      strobe   <= cmd.emit;
      last_out <= cmd.emit & sts.emit_last;
      if (cmd.load) begin
        lastr <= last_key;
      end
      if (cmd.emit) begin
        e <= e + AW'(1);
      end
      if (cmd.ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.place) begin
        count <= count + CW'(1);
      end
      if (cmd.finish) begin
        count <= '0;
        ovf   <= 1'b0;
        e     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      keyr <= key;
      j    <= count[AW-1:0];
    end else if (cmd.shift) begin
      j <= j - AW'(1);
    end
    if (cmd.emit) begin
      overflowed <= ovf;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/insertion_sort_with_index_top.sv @@
`default_nettype none

// Channel   Handshake       Beat fields
// input     start / busy    key, last_key
// result    strobe          sorted_key, source_index, last_out, overflowed
//
// Each key is inserted in order on arrival: after the key is accepted, stored
// entries are compared from the top down and shifted up while the key is smaller
// (one read and one write of the store RAM per cycle), then the key is written.
// A key that arrives with the store full is dropped.
// A last_key beat then emits its n results back to back, one RAM read each,
// and busy stays high until the last result is out. No clearing pass
// follows reset. The receiver cannot stall results.

module insertion_sort_with_index_top
  import iswi_pkg::*;
#(
  parameter int unsigned SIZE = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [KEY_W-1:0] key,
  input  wire logic                    last_key,
  output logic                         strobe,
  output logic signed [KEY_W-1:0]      sorted_key,
  output logic        [SRC_W-1:0]      source_index,
  output logic                         last_out,
  output logic                         overflowed
);

  cmd_t cmd;
  sts_t sts;

  iswi_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .last_key(last_key),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  iswi_dp #(
    .SIZE(SIZE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .key         (key),
    .last_key    (last_key),
    .sts         (sts),
    .strobe      (strobe),
    .sorted_key  (sorted_key),
    .source_index(source_index),
    .last_out    (last_out),
    .overflowed  (overflowed)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result beat outside a busy period");

  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    last_out |-> strobe)
    else $error("last_out without a result beat");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_out) |=> strobe)
    else $error("gap inside a result burst");

  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    last_out |=> !strobe)
    else $error("result beat after the last of a run");

endmodule

`default_nettype wire

@@ tb/sv/insertion_sort_with_index_top_tb.sv @@
module insertion_sort_with_index_top_tb;
  import iswi_pkg::*;

  localparam int unsigned RUN_CAP = 32;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TARGET_BEATS = 270;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef key_t key_q_t[$];

  typedef struct {
    key_t             k;
    logic [SRC_W-1:0] src;
    logic             lst;
    logic             ovf;
  } sorted_beat_t;

  class sort_scoreboard;
    int unsigned  cap;
    key_t         run_keys[$];
    logic         ovf_seen;
    sorted_beat_t pending[$];
    int unsigned  errors;

    function new(int unsigned c);
      cap = c;
      ovf_seen = 1'b0;
      errors = 0;
    endfunction

    function void note_key(key_t k, logic l);
      key_t             ks[$];
      logic [SRC_W-1:0] srcs[$];
      int               j;
      sorted_beat_t     b;
      if (run_keys.size() < cap) run_keys.push_back(k);
      else ovf_seen = 1'b1;
      if (!l) return;
      foreach (run_keys[i]) begin
        j = ks.size();
        while (j > 0 && run_keys[i] < ks[j-1]) j--;
        ks.insert(j, run_keys[i]);
        srcs.insert(j, SRC_W'(i));
      end
      foreach (ks[i]) begin
        b.k = ks[i];
        b.src = srcs[i];
        b.lst = (i == ks.size() - 1);
        b.ovf = ovf_seen;
        pending.push_back(b);
      end
      run_keys.delete();
      ovf_seen = 1'b0;
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(key_t k, logic [SRC_W-1:0] src, logic lst, logic ovf);
      sorted_beat_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result key %h src %0d", k, src));
        return;
      end
      e = pending.pop_front();
      if (k !== e.k) report($sformatf("sorted_key %h, want %h", k, e.k));
      if (src !== e.src) report($sformatf("source_index %0d, want %0d", src, e.src));
      if (lst !== e.lst) report($sformatf("last_out %b, want %b", lst, e.lst));
      if (ovf !== e.ovf) report($sformatf("overflowed %b, want %b", ovf, e.ovf));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  key_t             key = '0;
  logic             last_key = 1'b0;
  logic             strobe;
  key_t             sorted_key;
  logic [SRC_W-1:0] source_index;
  logic             last_out;
  logic             overflowed;

  sort_scoreboard sb = new(RUN_CAP);
  int unsigned    idle_pct = 0;
  int unsigned    beats_sent = 0;
  int unsigned    quiet_cycles = 0;

  always #4 clk = ~clk;

  insertion_sort_with_index_top #(.SIZE(RUN_CAP)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .key(key),
    .last_key(last_key),
    .strobe(strobe),
    .sorted_key(sorted_key),
    .source_index(source_index),
    .last_out(last_out),
    .overflowed(overflowed)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_key(key, last_key);
      if (strobe) sb.check_result(sorted_key, source_index, last_out, overflowed);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input key_t k, input logic l);
    start <= 1'b1;
    key <= k;
    last_key <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
  endtask

  task automatic maybe_idle();
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_run(input key_q_t ks);
    foreach (ks[i]) begin
      send_beat(ks[i], i == ks.size() - 1);
      maybe_idle();
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic key_t pick_key(int unsigned mode);
    case (mode)
      0: return key_t'($urandom);
      1: return (key_t'($urandom_range(0, 4)) - 2) * 65536;
      2: return key_t'($urandom_range(0, 131072) - 65536);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  initial begin
    key_q_t      run;
    int unsigned run_no;
    int unsigned len;
    int unsigned mode;
    int unsigned pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_run('{32'h7FFF_FFFF});
    send_run('{32'h8000_0000});
    send_run('{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
               32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
    send_run('{32'sd5, 32'sd4, 32'sd3, 32'sd2, 32'sd1});
    send_run('{-32'sd2, -32'sd1, 32'sd1, 32'sd2});
    drain();

    run_no = 0;
    while (beats_sent < TARGET_BEATS) begin
      case ((run_no / 3) % 3)
        0: idle_pct = 0;
        1: idle_pct = 66;
        default: idle_pct = 34;
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0) len = $urandom_range(RUN_CAP - 1, RUN_CAP + 6);
      else if (pick == 1) len = 1;
      else len = $urandom_range(2, 12);
      mode = $urandom_range(0, 3);
      run.delete();
      repeat (len) run.push_back(pick_key(mode));
      send_run(run);
      if (run_no % 7 == 6) drain();
      run_no++;
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
